[rtl/ppp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, request codes, datapath commands and helpers for the
// polyline path projection unit.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS      = 8;

  localparam int CRD_W = 24;                 // Q16.8 coordinate
  localparam int DIF_W = CRD_W + 1;          // coordinate difference
  localparam int DST_W = CRD_W + 4;          // distance along the segment
  localparam int PRD_W = DIF_W + DST_W;      // one product
  localparam int NUM_W = PRD_W + 1;          // sum of two products
  localparam int SQ_W  = 2 * DIF_W;          // square root working width
  localparam int LEN_W = DIF_W;              // rounded segment length
  localparam int DIV_W = 52;                 // dividend magnitude
  localparam int DCN_W = $clog2(DIV_W + 1);
  localparam int RES_W = CRD_W + 6;          // unsaturated result
  localparam int PC_W  = 7;
  localparam int IDX_W = 6;
  localparam int OFF_W = 16;
  localparam int REQ_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_AHEAD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NEAREST = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

  localparam logic [PC_W-1:0] POINT_COUNT_RST = 7'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_WRITE,
    DP_LOAD_Q,
    DP_SCAN,
    DP_RD_SNAP,
    DP_SNAP_RES,
    DP_RD_C,
    DP_RD_N,
    DP_RD_P,
    DP_GOT_P,
    DP_FWD_SQ1,
    DP_FWD_SQ2,
    DP_FWD_CMP,
    DP_SEG,
    DP_LEN_SQ,
    DP_DOT_SQ,
    DP_DOT_SUM,
    DP_ZERO_RES,
    DP_SQRT_STEP,
    DP_SQRT_RND,
    DP_DIVS_DOT,
    DP_DIVS_X,
    DP_DIVS_Y,
    DP_DIV_STEP,
    DP_PROJ,
    DP_DIST_MUL,
    DP_RES_X,
    DP_RES_Y,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic short_path;
    logic snap;
    logic scan_end;
    logic len_zero;
    logic sqrt_done;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] lo;
    logic signed [RES_W-1:0] hi;
    lo = -(RES_W'(1) <<< (CRD_W - 1));
    hi = (RES_W'(1) <<< (CRD_W - 1)) - RES_W'(1);
    if (v < lo) begin
      return CRD_W'(lo);
    end else if (v > hi) begin
      return CRD_W'(hi);
    end
    return CRD_W'(v);
  endfunction

endpackage

[rtl/ppp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ppp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_datapath
// Waypoint store, nearest point scan pipeline, two multipliers, square root
// and shared restoring divider, result and output registers.
// ----------------------------------------------------------------------------
module ppp_datapath #(
  parameter int MAX_POINTS = ppp_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ppp_pkg::dp_cmd_t                    cmd,
  output ppp_pkg::dp_status_t                 status,
  input  logic                                cfg_wr_en,
  input  logic [ppp_pkg::PC_W-1:0]            cfg_wr_data,
  input  logic [ppp_pkg::REQ_W-1:0]           req_type,
  input  logic [ppp_pkg::IDX_W-1:0]           point_index,
  input  logic signed [ppp_pkg::CRD_W-1:0]    coord_x,
  input  logic signed [ppp_pkg::CRD_W-1:0]    coord_y,
  input  logic signed [ppp_pkg::OFF_W-1:0]    lookahead_offset,
  output logic signed [ppp_pkg::CRD_W-1:0]    pos_x,
  output logic signed [ppp_pkg::CRD_W-1:0]    pos_y,
  output logic                                at_end,
  output logic [ppp_pkg::IDX_W-1:0]           segment_start
);
  import ppp_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (SQ_W - 2);

  logic [PC_W-1:0] point_count;
  logic [CW-1:0]   n;
  logic [CW-1:0]   last;

  logic signed [CRD_W-1:0] qx, qy, cx, cy, nx, ny, px, py;
  logic signed [OFF_W-1:0] off;
  logic                    ahead;
  logic                    fwd;

  logic [AW-1:0] i, i1, i2, c;
  logic          v1, v2;
  logic signed [NUM_W-1:0] best, e1, len2, num, psum;

  logic              ram_we;
  logic [AW-1:0]     raddr;
  logic [2*CRD_W-1:0] rdata;
  logic signed [CRD_W-1:0] wx, wy;

  logic signed [DIF_W-1:0] sx, sy, tx, ty;
  logic signed [DIF_W-1:0] ma_x, ma_y;
  logic signed [DST_W-1:0] mb_x, mb_y;
  logic                    mul_en;
  logic signed [PRD_W-1:0] prod_x, prod_y;

  logic [SQ_W-1:0] sq_x, sq_r, sq_b, sq_t;
  logic [LEN_W-1:0] len;

  logic [DIV_W-1:0] dvd;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   rsh;
  logic             ge;
  logic [DCN_W-1:0] dcnt;
  logic             dneg;
  logic signed [DIV_W:0] dq;
  logic signed [NUM_W-1:0] dsrc, dmag;

  logic signed [DST_W-1:0] along;
  logic signed [RES_W-1:0] rx, ry;
  logic                    rend;

  assign wx = rdata[2*CRD_W-1:CRD_W];
  assign wy = rdata[CRD_W-1:0];

  assign n    = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign last = n - CW'(1);
  assign psum = NUM_W'(prod_x) + NUM_W'(prod_y);

  assign status.short_path = n < CW'(2);
  assign status.snap       = (n < CW'(2)) || ((CW'(c) + CW'(1)) == last);
  assign status.scan_end   = CW'(i) == (last - CW'(1));
  assign status.len_zero   = len2 == '0;
  assign status.sqrt_done  = sq_b == '0;
  assign status.div_done   = dcnt == '0;

  assign ram_we = (cmd.op == DP_WRITE) && (32'(point_index) < MAX_POINTS);

  ppp_ram #(
    .WIDTH(2 * CRD_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(point_index)),
    .wdata({coord_x, coord_y}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    case (cmd.op)
      DP_RD_SNAP: raddr = status.short_path ? '0 : AW'(last);
      DP_RD_C:    raddr = c;
      DP_RD_N:    raddr = c + AW'(1);
      DP_RD_P:    raddr = c - AW'(1);
      default:    raddr = i;
    endcase
  end

  // the scan pipeline owns the multipliers whenever a read is in flight
  always_comb begin
    mul_en = 1'b1;
    ma_x = sx;
    ma_y = sy;
    mb_x = DST_W'(sx);
    mb_y = DST_W'(sy);
    if (v1) begin
      ma_x = DIF_W'(qx) - DIF_W'(wx);
      ma_y = DIF_W'(qy) - DIF_W'(wy);
      mb_x = DST_W'(ma_x);
      mb_y = DST_W'(ma_y);
    end else begin
      case (cmd.op)
        DP_FWD_SQ1: begin
          ma_x = DIF_W'(cx) - DIF_W'(nx);
          ma_y = DIF_W'(cy) - DIF_W'(ny);
          mb_x = DST_W'(ma_x);
          mb_y = DST_W'(ma_y);
        end
        DP_FWD_SQ2: begin
          ma_x = DIF_W'(qx) - DIF_W'(nx);
          ma_y = DIF_W'(qy) - DIF_W'(ny);
          mb_x = DST_W'(ma_x);
          mb_y = DST_W'(ma_y);
        end
        DP_LEN_SQ: ;
        DP_DOT_SQ: begin
          mb_x = DST_W'(tx);
          mb_y = DST_W'(ty);
        end
        DP_DIST_MUL: begin
          mb_x = along;
          mb_y = along;
        end
        default: mul_en = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      DP_DIVS_X: dsrc = NUM_W'(prod_x);
      DP_DIVS_Y: dsrc = NUM_W'(prod_y);
      default:   dsrc = num;
    endcase
    dmag = dsrc[NUM_W-1] ? -dsrc : dsrc;
    sq_t = sq_r + sq_b;
    rsh  = {rem, dvd[DIV_W-1]};
    ge   = rsh >= {1'b0, len};
    dq   = dneg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
      v1 <= cmd.op == DP_SCAN;
      v2 <= v1;
    end

    i1 <= i;
    i2 <= i1;
    if (mul_en) begin
      prod_x <= ma_x * mb_x;
      prod_y <= ma_y * mb_y;
    end
    // strict compare keeps the earliest waypoint on a tie
    if (v2 && ((i2 == '0) || (best > psum))) begin
      best <= psum;
      c    <= i2;
    end

    case (cmd.op)
      DP_LOAD_Q: begin
        qx    <= coord_x;
        qy    <= coord_y;
        ahead <= req_type == REQ_AHEAD;
        off   <= (req_type == REQ_AHEAD) ? lookahead_offset : '0;
        i     <= '0;
        c     <= '0;
        rend  <= 1'b0;
      end
      DP_SCAN: i <= i + AW'(1);
      DP_SNAP_RES: begin
        rx   <= RES_W'(wx);
        ry   <= RES_W'(wy);
        rend <= 1'b1;
      end
      DP_RD_N: begin
        cx <= wx;
        cy <= wy;
      end
      DP_RD_P: begin
        nx <= wx;
        ny <= wy;
      end
      DP_GOT_P: begin
        px <= wx;
        py <= wy;
      end
      DP_FWD_SQ2: e1 <= psum;
      DP_FWD_CMP: fwd <= ahead || (c == '0) || (e1 > psum);
      DP_SEG: begin
        sx <= (fwd ? DIF_W'(nx) : DIF_W'(px)) - DIF_W'(cx);
        sy <= (fwd ? DIF_W'(ny) : DIF_W'(py)) - DIF_W'(cy);
        tx <= DIF_W'(qx) - DIF_W'(cx);
        ty <= DIF_W'(qy) - DIF_W'(cy);
      end
      DP_DOT_SQ: len2 <= psum;
      DP_DOT_SUM: begin
        num  <= psum;
        sq_x <= SQ_W'(len2);
        sq_r <= '0;
        sq_b <= SQ_TOP;
      end
      DP_ZERO_RES: begin
        rx <= RES_W'(cx);
        ry <= RES_W'(cy);
      end
      DP_SQRT_STEP: begin
        if (sq_x >= sq_t) begin
          sq_x <= sq_x - sq_t;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      // round to nearest: remainder above the root means the upper integer
      DP_SQRT_RND: len <= LEN_W'(sq_r) + LEN_W'(sq_x > sq_r);
      DP_DIVS_DOT, DP_DIVS_X, DP_DIVS_Y: begin
        dvd  <= DIV_W'(dmag) + DIV_W'(len >> 1);
        dneg <= dsrc[NUM_W-1];
        rem  <= '0;
        dcnt <= DCN_W'(DIV_W);
      end
      DP_DIV_STEP: begin
        rem  <= ge ? LEN_W'(rsh - {1'b0, len}) : LEN_W'(rsh);
        dvd  <= {dvd[DIV_W-2:0], ge};
        dcnt <= dcnt - DCN_W'(1);
      end
      DP_PROJ: along <= (dq < 0 ? DST_W'(0) : DST_W'(dq)) + (DST_W'(off) <<< FRAC_BITS);
      DP_RES_X: rx <= RES_W'(cx) + RES_W'(dq);
      DP_RES_Y: ry <= RES_W'(cy) + RES_W'(dq);
      DP_OUT: begin
        pos_x         <= sat_crd(rx);
        pos_y         <= sat_crd(ry);
        at_end        <= rend;
        segment_start <= IDX_W'(c);
      end
      default: ;
    endcase
  end

endmodule

[rtl/ppp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_ctrl
// Sequencer for the projection datapath: scan, segment choice, square root,
// three divisions and the output handshake.
// ----------------------------------------------------------------------------
module ppp_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ppp_pkg::REQ_W-1:0] req_type,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ppp_pkg::dp_cmd_t          cmd,
  input  ppp_pkg::dp_status_t       status
);
  import ppp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_DRAIN1, S_DRAIN2, S_DECIDE, S_SNAPW,
    S_RDN, S_RDP, S_GOTP, S_F1, S_F2, S_F3, S_SEG, S_LSQ, S_DSQ, S_DSUM,
    S_ZERO, S_SQRT, S_RND, S_D1S, S_D1, S_PROJ, S_DMUL, S_D2S, S_D2,
    S_RESX, S_D3S, S_D3, S_RESY, S_OUT
  } state_t;

  state_t state;
  logic   is_query;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign is_query = (req_type == REQ_AHEAD) || (req_type == REQ_NEAREST);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.op = DP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid && req_type == REQ_LOAD) begin
          cmd.op = DP_WRITE;
        end else if (in_valid && is_query) begin
          cmd.op = DP_LOAD_Q;
        end
      end
      S_SCAN:   cmd.op = DP_SCAN;
      S_DECIDE: cmd.op = status.snap ? DP_RD_SNAP : DP_RD_C;
      S_SNAPW:  cmd.op = DP_SNAP_RES;
      S_RDN:    cmd.op = DP_RD_N;
      S_RDP:    cmd.op = DP_RD_P;
      S_GOTP:   cmd.op = DP_GOT_P;
      S_F1:     cmd.op = DP_FWD_SQ1;
      S_F2:     cmd.op = DP_FWD_SQ2;
      S_F3:     cmd.op = DP_FWD_CMP;
      S_SEG:    cmd.op = DP_SEG;
      S_LSQ:    cmd.op = DP_LEN_SQ;
      S_DSQ:    cmd.op = DP_DOT_SQ;
      S_DSUM:   cmd.op = DP_DOT_SUM;
      S_ZERO:   cmd.op = DP_ZERO_RES;
      S_SQRT:   cmd.op = status.sqrt_done ? DP_NOP : DP_SQRT_STEP;
      S_RND:    cmd.op = DP_SQRT_RND;
      S_D1S:    cmd.op = DP_DIVS_DOT;
      S_D2S:    cmd.op = DP_DIVS_X;
      S_D3S:    cmd.op = DP_DIVS_Y;
      S_D1, S_D2, S_D3: cmd.op = status.div_done ? DP_NOP : DP_DIV_STEP;
      S_PROJ:   cmd.op = DP_PROJ;
      S_DMUL:   cmd.op = DP_DIST_MUL;
      S_RESX:   cmd.op = DP_RES_X;
      S_RESY:   cmd.op = DP_RES_Y;
      S_OUT:    cmd.op = out_free ? DP_OUT : DP_NOP;
      default:  cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && is_query) begin
            state <= status.short_path ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN:   if (status.scan_end) state <= S_DRAIN1;
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_DECIDE;
        S_DECIDE: state <= status.snap ? S_SNAPW : S_RDN;
        S_SNAPW:  state <= S_OUT;
        S_RDN:    state <= S_RDP;
        S_RDP:    state <= S_GOTP;
        S_GOTP:   state <= S_F1;
        S_F1:     state <= S_F2;
        S_F2:     state <= S_F3;
        S_F3:     state <= S_SEG;
        S_SEG:    state <= S_LSQ;
        S_LSQ:    state <= S_DSQ;
        S_DSQ:    state <= S_DSUM;
        S_DSUM:   state <= status.len_zero ? S_ZERO : S_SQRT;
        S_ZERO:   state <= S_OUT;
        S_SQRT:   if (status.sqrt_done) state <= S_RND;
        S_RND:    state <= S_D1S;
        S_D1S:    state <= S_D1;
        S_D1:     if (status.div_done) state <= S_PROJ;
        S_PROJ:   state <= S_DMUL;
        S_DMUL:   state <= S_D2S;
        S_D2S:    state <= S_D2;
        S_D2:     if (status.div_done) state <= S_RESX;
        S_RESX:   state <= S_D3S;
        S_D3S:    state <= S_D3;
        S_D3:     if (status.div_done) state <= S_RESY;
        S_RESY:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/polyline_path_projection_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_path_projection_unit
// Waypoint path store with nearest waypoint search and projection of a
// query position onto the chosen path segment.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    req_type, point_index, coord_x, coord_y,
//                                  lookahead_offset
//  out      out_valid / out_ready  pos_x, pos_y, at_end, segment_start
//  cfg      cfg_wr_en              cfg_wr_data (point_count)
//
//  a load item never stalls the input; a query holds in_ready low until it
//  finishes, whether it snaps to the end or projects onto a segment, and its
//  pace is set by the one-read-per-cycle scan and the bit serial root and divider
//  the finished result sits in an output register, so a waiting result only
//  holds back the next query at its very end
//  rst is synchronous; the waypoint store is not cleared
// ----------------------------------------------------------------------------
module polyline_path_projection_unit #(
  parameter int MAX_POINTS = ppp_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ppp_pkg::REQ_W-1:0]        req_type,
  input  logic [ppp_pkg::IDX_W-1:0]        point_index,
  input  logic signed [ppp_pkg::CRD_W-1:0] coord_x,
  input  logic signed [ppp_pkg::CRD_W-1:0] coord_y,
  input  logic signed [ppp_pkg::OFF_W-1:0] lookahead_offset,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ppp_pkg::CRD_W-1:0] pos_x,
  output logic signed [ppp_pkg::CRD_W-1:0] pos_y,
  output logic                             at_end,
  output logic [ppp_pkg::IDX_W-1:0]        segment_start,
  input  logic                             cfg_wr_en,
  input  logic [ppp_pkg::PC_W-1:0]         cfg_wr_data
);
  import ppp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ppp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status)
  );

  ppp_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .req_type        (req_type),
    .point_index     (point_index),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .lookahead_offset(lookahead_offset),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .at_end          (at_end),
    .segment_start   (segment_start)
  );

endmodule

[rtl/ppp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_checker
// Port level checks for the polyline path projection unit.
// ----------------------------------------------------------------------------
module ppp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [ppp_pkg::REQ_W-1:0]        req_type,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [ppp_pkg::CRD_W-1:0] pos_x,
  input logic signed [ppp_pkg::CRD_W-1:0] pos_y,
  input logic                             at_end,
  input logic [ppp_pkg::IDX_W-1:0]        segment_start
);
  import ppp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(at_end) && $stable(segment_start))
    else $error("result changed while stalled");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_AHEAD || req_type == REQ_NEAREST)
      |=> !in_ready)
    else $error("item accepted during a query");

  // a load does not stall the input
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_LOAD |=> in_ready)
    else $error("load item stalled the input");

  // a result never appears without a query in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a query");

endmodule

bind polyline_path_projection_unit ppp_checker u_ppp_checker (.*);
